/* sv/cri_pkg.sv */
// Shared constants and register codes for the cable robot inverse kinematics block.
package cri_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int LEN_BITS           = 18;
    localparam int NUM_LANES          = 3;
    localparam int CFG_INDEX_BITS     = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_BASE_SPAN   = 2'd0,
        REG_ANCHOR_Q_X  = 2'd1,
        REG_ANCHOR_Q_Y  = 2'd2,
        REG_MOUNT_LEVEL = 2'd3
    } cfg_reg_t;

endpackage

/* sv/cri_if.sv */
// Channel interfaces for target points, cable lengths and register writes.
interface cri_target_if #(
    parameter int COORD_BITS = cri_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

interface cri_length_if;
    logic                         valid;
    logic                         ready;
    logic [cri_pkg::LEN_BITS-1:0] length_from_origin;
    logic [cri_pkg::LEN_BITS-1:0] length_from_second;
    logic [cri_pkg::LEN_BITS-1:0] length_from_third;

    modport source (output valid, output length_from_origin, output length_from_second,
                    output length_from_third, input ready);
    modport sink   (input valid, input length_from_origin, input length_from_second,
                    input length_from_third, output ready);
endinterface

interface cri_cfg_if #(
    parameter int COORD_BITS = cri_pkg::COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    cri_pkg::cfg_reg_t            index;
    logic [COORD_BITS-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/cri_front.sv */
// Front pipeline: coordinate differences, squares and per-cable sums of squares.
module cri_front #(
    parameter int COORD_BITS = cri_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic [2:0]                                          adv,
    input  logic                                                in_valid,
    input  logic signed [COORD_BITS-1:0]                        target_x,
    input  logic signed [COORD_BITS-1:0]                        target_y,
    input  logic signed [COORD_BITS-1:0]                        target_z,
    input  logic [COORD_BITS-1:0]                               base_span,
    input  logic signed [COORD_BITS-1:0]                        anchor_q_x,
    input  logic signed [COORD_BITS-1:0]                        anchor_q_y,
    input  logic [COORD_BITS-1:0]                               mount_level,
    output logic [2:0]                                          vld,
    output logic [cri_pkg::NUM_LANES-1:0][2*COORD_BITS+3:0]     sums
);
    localparam int EXT_BITS  = COORD_BITS + 2;
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS  = SQ_BITS + 2;
    localparam int NUM_TERMS = 6;

    // Term order: x, x - span, x - qx, y, y - qy, z - level.
    logic signed [NUM_TERMS-1:0][EXT_BITS-1:0] diff;
    logic [NUM_TERMS-1:0][DIFF_BITS-1:0]       abs_next;
    logic [NUM_TERMS-1:0][DIFF_BITS-1:0]       abs_reg;
    logic [NUM_TERMS-1:0][SQ_BITS-1:0]         sq_next;
    logic [NUM_TERMS-1:0][SQ_BITS-1:0]         sq_reg;
    logic [cri_pkg::NUM_LANES-1:0][SUM_BITS-1:0] sum_next;
    logic [cri_pkg::NUM_LANES-1:0][SUM_BITS-1:0] sum_reg;
    logic [2:0]                                vld_reg;
    logic [2:0]                                vld_next;

    always_comb
    begin
        diff[0] = EXT_BITS'(target_x);
        diff[1] = EXT_BITS'(target_x) - $signed({2'b00, base_span});
        diff[2] = EXT_BITS'(target_x) - EXT_BITS'(anchor_q_x);
        diff[3] = EXT_BITS'(target_y);
        diff[4] = EXT_BITS'(target_y) - EXT_BITS'(anchor_q_y);
        diff[5] = EXT_BITS'(target_z) - $signed({2'b00, mount_level});
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            if (diff[i][EXT_BITS-1])
            begin
                abs_next[i] = DIFF_BITS'(-diff[i]);
            end
            else
            begin
                abs_next[i] = DIFF_BITS'(diff[i]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            sq_next[i] = abs_reg[i] * abs_reg[i];
        end
    end

    always_comb
    begin
        sum_next[0] = SUM_BITS'(sq_reg[0]) + SUM_BITS'(sq_reg[3]) + SUM_BITS'(sq_reg[5]);
        sum_next[1] = SUM_BITS'(sq_reg[1]) + SUM_BITS'(sq_reg[3]) + SUM_BITS'(sq_reg[5]);
        sum_next[2] = SUM_BITS'(sq_reg[2]) + SUM_BITS'(sq_reg[4]) + SUM_BITS'(sq_reg[5]);
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0]) vld_next[0] = in_valid;
        if (adv[1]) vld_next[1] = vld_reg[0];
        if (adv[2]) vld_next[2] = vld_reg[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0]) abs_reg <= abs_next;
        if (adv[1]) sq_reg  <= sq_next;
        if (adv[2]) sum_reg <= sum_next;
    end

    assign vld  = vld_reg;
    assign sums = sum_reg;

endmodule

/* sv/cri_sqrt_cell.sv */
// One square-root cell: resolves one root bit for each of the three cables.
module cri_sqrt_cell #(
    parameter int ROOT_BITS = cri_pkg::COORD_BITS_DEFAULT + 2
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            adv,
    input  logic                                            valid_in,
    input  logic [cri_pkg::NUM_LANES-1:0][2*ROOT_BITS-1:0]  val_in,
    input  logic [cri_pkg::NUM_LANES-1:0][ROOT_BITS+1:0]    rem_in,
    input  logic [cri_pkg::NUM_LANES-1:0][ROOT_BITS-1:0]    root_in,
    output logic                                            valid_out,
    output logic [cri_pkg::NUM_LANES-1:0][2*ROOT_BITS-1:0]  val_out,
    output logic [cri_pkg::NUM_LANES-1:0][ROOT_BITS+1:0]    rem_out,
    output logic [cri_pkg::NUM_LANES-1:0][ROOT_BITS-1:0]    root_out
);
    localparam int VAL_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 2;

    logic [cri_pkg::NUM_LANES-1:0][VAL_BITS-1:0]  val_next;
    logic [cri_pkg::NUM_LANES-1:0][REM_BITS-1:0]  rem_next;
    logic [cri_pkg::NUM_LANES-1:0][ROOT_BITS-1:0] root_next;
    logic [cri_pkg::NUM_LANES-1:0][VAL_BITS-1:0]  val_reg;
    logic [cri_pkg::NUM_LANES-1:0][REM_BITS-1:0]  rem_reg;
    logic [cri_pkg::NUM_LANES-1:0][ROOT_BITS-1:0] root_reg;
    logic                                         valid_reg;
    logic [REM_BITS-1:0]                          rem_sh;
    logic [REM_BITS-1:0]                          trial;

    // Restoring square root: bring down the next two radicand bits and try
    // appending a one to the partial root.
    always_comb
    begin
        rem_sh = '0;
        trial  = '0;
        for (int l = 0; l < cri_pkg::NUM_LANES; l++)
        begin
            rem_sh      = {rem_in[l][REM_BITS-3:0], val_in[l][VAL_BITS-1:VAL_BITS-2]};
            trial       = {root_in[l], 2'b01};
            val_next[l] = {val_in[l][VAL_BITS-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next[l]  = rem_sh - trial;
                root_next[l] = {root_in[l][ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[l]  = rem_sh;
                root_next[l] = {root_in[l][ROOT_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign valid_out = valid_reg;
    assign val_out   = val_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

/* sv/cable_robot_inverse_kinematics.sv */
// Top level of the three-cable robot inverse kinematics pipeline.
//
// The block turns a target point into the three cable lengths that reach it.
// Target points arrive on the target channel; one result per point leaves on
// the length channel, in order. Anchor geometry is held in four registers
// written through the cfg channel, which is always ready and takes one write
// per cycle; writes are meant to happen only while no point is in flight.
//
// A point passes through three front stages (differences, squares, sums)
// followed by a chain of COORD_BITS + 2 square-root cells, each deciding one
// root bit for all three cables. Throughput is one point per cycle while the
// receiver does not stall, set by the pipeline having a register per stage
// and no shared unit.
//
// The last cell is the output register. When the receiver stalls, the result
// holds there, and empty stages upstream keep filling, so input is still
// taken until the whole pipeline is full. Reset empties the pipeline and
// sets span 1, third anchor (1, 1) and mount level 0.
module cable_robot_inverse_kinematics #(
    parameter int COORD_BITS = cri_pkg::COORD_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    cri_target_if.sink    target,
    cri_length_if.source  length,
    cri_cfg_if.sink       cfg
);
    localparam int ROOT_BITS  = COORD_BITS + 2;
    localparam int VAL_BITS   = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int NUM_STAGES = 3 + ROOT_BITS;
    localparam int NL         = cri_pkg::NUM_LANES;

    // Anchor geometry registers.
    logic [COORD_BITS-1:0]        base_span_reg;
    logic [COORD_BITS-1:0]        base_span_next;
    logic signed [COORD_BITS-1:0] anchor_q_x_reg;
    logic signed [COORD_BITS-1:0] anchor_q_x_next;
    logic signed [COORD_BITS-1:0] anchor_q_y_reg;
    logic signed [COORD_BITS-1:0] anchor_q_y_next;
    logic [COORD_BITS-1:0]        mount_level_reg;
    logic [COORD_BITS-1:0]        mount_level_next;
    logic                         cfg_write;

    // Per-stage occupancy and advance. A stage may load when it is empty or
    // when the stage after it is loading too.
    logic [NUM_STAGES-1:0]        vld_all;
    logic [NUM_STAGES-1:0]        adv_all;
    logic [2:0]                   front_vld;

    logic [NL-1:0][VAL_BITS-1:0]  val_c  [0:ROOT_BITS];
    logic [NL-1:0][REM_BITS-1:0]  rem_c  [0:ROOT_BITS];
    logic [NL-1:0][ROOT_BITS-1:0] root_c [0:ROOT_BITS];
    logic [ROOT_BITS:0]           valid_c;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_comb
    begin
        base_span_next   = base_span_reg;
        anchor_q_x_next  = anchor_q_x_reg;
        anchor_q_y_next  = anchor_q_y_reg;
        mount_level_next = mount_level_reg;
        if (cfg_write)
        begin
            unique case (cfg.index)
                cri_pkg::REG_BASE_SPAN:   base_span_next   = cfg.data;
                cri_pkg::REG_ANCHOR_Q_X:  anchor_q_x_next  = cfg.data;
                cri_pkg::REG_ANCHOR_Q_Y:  anchor_q_y_next  = cfg.data;
                cri_pkg::REG_MOUNT_LEVEL: mount_level_next = cfg.data;
                default:                  base_span_next   = base_span_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_span_reg   <= COORD_BITS'(1);
            anchor_q_x_reg  <= COORD_BITS'(1);
            anchor_q_y_reg  <= COORD_BITS'(1);
            mount_level_reg <= '0;
        end
        else
        begin
            base_span_reg   <= base_span_next;
            anchor_q_x_reg  <= anchor_q_x_next;
            anchor_q_y_reg  <= anchor_q_y_next;
            mount_level_reg <= mount_level_next;
        end
    end

    // The advance chain runs back from the output register to the input.
    always_comb
    begin
        adv_all[NUM_STAGES-1] = !vld_all[NUM_STAGES-1] || length.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            adv_all[k] = !vld_all[k] || adv_all[k+1];
        end
    end

    assign target.ready = adv_all[0];

    cri_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv_all[2:0]),
        .in_valid    (target.valid),
        .target_x    (target.target_x),
        .target_y    (target.target_y),
        .target_z    (target.target_z),
        .base_span   (base_span_reg),
        .anchor_q_x  (anchor_q_x_reg),
        .anchor_q_y  (anchor_q_y_reg),
        .mount_level (mount_level_reg),
        .vld         (front_vld),
        .sums        (val_c[0])
    );

    // The chain starts with an empty remainder and an empty partial root.
    assign rem_c[0]   = '0;
    assign root_c[0]  = '0;
    assign valid_c[0] = front_vld[2];

    for (genvar c = 0; c < ROOT_BITS; c++)
    begin : g_cell
        cri_sqrt_cell #(
            .ROOT_BITS (ROOT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv_all[3+c]),
            .valid_in  (valid_c[c]),
            .val_in    (val_c[c]),
            .rem_in    (rem_c[c]),
            .root_in   (root_c[c]),
            .valid_out (valid_c[c+1]),
            .val_out   (val_c[c+1]),
            .rem_out   (rem_c[c+1]),
            .root_out  (root_c[c+1])
        );
    end

    assign vld_all = {valid_c[ROOT_BITS:1], front_vld};

    // Lengths wider than the output field keep their low bits.
    assign length.valid              = valid_c[ROOT_BITS];
    assign length.length_from_origin = cri_pkg::LEN_BITS'(root_c[ROOT_BITS][0]);
    assign length.length_from_second = cri_pkg::LEN_BITS'(root_c[ROOT_BITS][1]);
    assign length.length_from_third  = cri_pkg::LEN_BITS'(root_c[ROOT_BITS][2]);

    // An accepted point occupies the first stage in the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (target.valid && target.ready) |=> vld_all[0])
        else $error("accepted point did not enter the first stage");

    // A stage holding a point that was not allowed to advance keeps it.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((vld_all & $past(vld_all & ~adv_all)) == $past(vld_all & ~adv_all)))
        else $error("a stalled stage lost its point");

    // With the output stage empty, the input side must be open.
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_all[NUM_STAGES-1] |-> target.ready)
        else $error("input blocked while output stage is empty");

    // A span write lands in its register.
    a_span_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg.index == cri_pkg::REG_BASE_SPAN)
        |=> base_span_reg == $past(cfg.data))
        else $error("base span write not taken");

endmodule
